// ----- rtl/core/tcv_pkg.sv -----
// tcv_pkg: shared constants, token type and expansion tables of the converter
package tcv_pkg;

    localparam int DELIM_MAX = 4;
    localparam int LEN_CAP   = (DELIM_MAX < 4) ? DELIM_MAX : 4;
    localparam int QDEPTH    = 4;

    localparam logic [1:0] CFG_BEGIN_DELIM = 2'd0;
    localparam logic [1:0] CFG_BEGIN_LEN   = 2'd1;
    localparam logic [1:0] CFG_END_DELIM   = 2'd2;
    localparam logic [1:0] CFG_END_LEN     = 2'd3;

    typedef enum logic [2:0] {
        K_PRE   = 3'd0,
        K_TEXT  = 3'd1,
        K_CODE  = 3'd2,
        K_CLOSE = 3'd3,
        K_MARK  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       open;
        logic [7:0] ch;
    } t_tok;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PRE  = 5'b00010,
        S_STEP = 5'b00100,
        S_TAIL = 5'b01000,
        S_MARK = 5'b10000
    } t_fstate;

    function automatic logic [2:0] eff_len(input logic [2:0] r);
        logic [2:0] v;
        v = r;
        if (v == 3'd0) v = 3'd1;
        if (v > 3'(LEN_CAP)) v = 3'(LEN_CAP);
        return v;
    endfunction

    function automatic logic [7:0] pre_byte(input logic [2:0] i);
        case (i)
            3'd0:    return "$";
            3'd1:    return "|";
            3'd2:    return " ";
            3'd3:    return "=";
            3'd4:    return " ";
            3'd5:    return "1";
            default: return ";";
        endcase
    endfunction

    function automatic logic [7:0] print_byte(input logic [2:0] i);
        case (i)
            3'd0:    return "p";
            3'd1:    return "r";
            3'd2:    return "i";
            3'd3:    return "n";
            3'd4:    return "t";
            3'd5:    return " ";
            default: return "\"";
        endcase
    endfunction

    function automatic logic [7:0] nl_byte(input logic [2:0] i);
        case (i)
            3'd0:    return "\\";
            3'd1:    return "n";
            3'd2:    return "\"";
            3'd3:    return ";";
            default: return "\n";
        endcase
    endfunction

    function automatic logic [4:0] esc_len(input logic [7:0] ch);
        if (ch inside {"\"", "@", "$", "\\", "\t"}) return 5'd2;
        else if (ch == "\n") return 5'd12;
        else return 5'd1;
    endfunction

    function automatic logic [7:0] esc_byte(input logic [7:0] ch, input logic [4:0] j);
        logic [4:0] k;
        k = j - 5'd5;
        if (ch inside {"\"", "@", "$", "\\"}) return (j == 5'd0) ? 8'("\\") : ch;
        else if (ch == "\t") return (j == 5'd0) ? 8'("\\") : 8'("t");
        else if (ch == "\n") return (j < 5'd5) ? nl_byte(j[2:0]) : print_byte(k[2:0]);
        else return ch;
    endfunction

    function automatic logic [4:0] tok_len(input t_tok t);
        case (t.kind)
            K_PRE:   return 5'd7;
            K_TEXT:  return (t.open ? 5'd7 : 5'd0) + esc_len(t.ch);
            K_CLOSE: return 5'd2;
            default: return 5'd1;
        endcase
    endfunction

    function automatic logic [7:0] tok_byte(input t_tok t, input logic [4:0] idx);
        logic [4:0] j;
        j = t.open ? (idx - 5'd7) : idx;
        case (t.kind)
            K_PRE:   return pre_byte(idx[2:0]);
            K_TEXT:  return (t.open && idx < 5'd7) ? print_byte(idx[2:0]) : esc_byte(t.ch, j);
            K_CLOSE: return (idx == 5'd0) ? 8'("\"") : 8'(";");
            default: return t.ch;
        endcase
    endfunction

endpackage

// ----- rtl/core/tcv_front.sv -----
// tcv_front: accepts document bytes, resolves delimiters and queues tokens
module tcv_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_byte,
    input  logic            i_eoi,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output logic            o_push,
    output tcv_pkg::t_tok   o_tok,
    input  logic            i_q_full
);

    tcv_pkg::t_fstate r_state, n_state;
    logic [31:0] r_bdelim, r_edelim;
    logic [2:0]  r_blen, r_elen;
    logic        r_started, n_started;
    logic        r_in_code, n_in_code;
    logic        r_skip, n_skip;
    logic        r_seg, n_seg;
    logic        r_inq, n_inq;
    logic [7:0]  r_prev, n_prev;
    logic [7:0]  r_held [3], n_held [3];
    logic [1:0]  r_hcnt, n_hcnt;
    logic [7:0]  r_wb [4], n_wb [4];
    logic [2:0]  r_wn, n_wn, r_ws, n_ws;
    logic        r_final, n_final;

    logic        adv, acc, match, quote, m;
    logic [2:0]  rem, len, ix;
    logic [7:0]  x, bl;
    logic [31:0] d;

    assign o_cfg_ready = 1'b1;
    assign adv = !i_q_full;
    assign o_stall = (r_state != tcv_pkg::S_IDLE) && !(r_state == tcv_pkg::S_MARK && adv);
    assign acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bdelim <= 32'd16188;
            r_blen   <= 3'd2;
            r_edelim <= 32'd15905;
            r_elen   <= 3'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tcv_pkg::CFG_BEGIN_DELIM: r_bdelim <= i_cfg_data;
                tcv_pkg::CFG_BEGIN_LEN:   r_blen   <= i_cfg_data[2:0];
                tcv_pkg::CFG_END_DELIM:   r_edelim <= i_cfg_data;
                tcv_pkg::CFG_END_LEN:     r_elen   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_in_code = r_in_code;
        n_skip    = r_skip;
        n_seg     = r_seg;
        n_inq     = r_inq;
        n_prev    = r_prev;
        n_held    = r_held;
        n_hcnt    = r_hcnt;
        n_wb      = r_wb;
        n_wn      = r_wn;
        n_ws      = r_ws;
        n_final   = r_final;
        o_push    = 1'b0;
        o_tok     = '{kind: tcv_pkg::K_MARK, open: 1'b0, ch: 8'd0};

        rem   = r_wn - r_ws;
        x     = r_wb[r_ws[1:0]];
        d     = r_in_code ? r_edelim : r_bdelim;
        len   = tcv_pkg::eff_len(r_in_code ? r_elen : r_blen);
        bl    = 8'(r_bdelim >> {tcv_pkg::eff_len(r_blen) - 3'd1, 3'b000});
        quote = (x == "\"") && (r_prev != "\\");
        match = 1'b1;
        for (int i = 0; i < 4; i++) begin
            ix = r_ws + 3'(i);
            if (3'(i) < rem && r_wb[ix[1:0]] != d[8*i +: 8]) match = 1'b0;
        end
        m = !r_final && rem <= len && match && (!r_in_code || (!r_inq && !quote));

        case (r_state)
            tcv_pkg::S_PRE: begin
                if (adv) begin
                    o_push     = 1'b1;
                    o_tok.kind = tcv_pkg::K_PRE;
                    n_state    = tcv_pkg::S_STEP;
                end
            end
            tcv_pkg::S_STEP: begin
                if (adv) begin
                    if (r_ws >= r_wn) begin
                        n_state = r_final ? tcv_pkg::S_TAIL : tcv_pkg::S_MARK;
                    end else if (m) begin
                        n_state = tcv_pkg::S_MARK;
                        if (rem == len) begin
                            if (!r_in_code) begin
                                if (r_seg) begin
                                    o_push     = 1'b1;
                                    o_tok.kind = tcv_pkg::K_CLOSE;
                                end
                                n_seg     = 1'b0;
                                n_in_code = 1'b1;
                                n_skip    = 1'b1;
                                n_inq     = 1'b0;
                                n_prev    = bl;
                            end else begin
                                n_in_code = 1'b0;
                            end
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                ix = r_ws + 3'(k);
                                n_held[k] = r_wb[ix[1:0]];
                            end
                            n_hcnt = rem[1:0];
                        end
                    end else begin
                        o_push   = 1'b1;
                        o_tok.ch = x;
                        if (!r_in_code) begin
                            o_tok.kind = tcv_pkg::K_TEXT;
                            o_tok.open = !r_seg;
                            n_seg      = 1'b1;
                        end else begin
                            o_tok.kind = tcv_pkg::K_CODE;
                            if (quote) n_inq = !r_inq;
                            n_prev = x;
                        end
                        n_ws = r_ws + 3'd1;
                        if (r_ws + 3'd1 == r_wn)
                            n_state = r_final ? tcv_pkg::S_TAIL : tcv_pkg::S_MARK;
                    end
                end
            end
            tcv_pkg::S_TAIL: begin
                if (adv) begin
                    if (!r_in_code && r_seg) begin
                        o_push     = 1'b1;
                        o_tok.kind = tcv_pkg::K_CLOSE;
                    end
                    n_started = 1'b0;
                    n_in_code = 1'b0;
                    n_skip    = 1'b0;
                    n_seg     = 1'b0;
                    n_inq     = 1'b0;
                    n_prev    = 8'd0;
                    n_hcnt    = 2'd0;
                    n_state   = tcv_pkg::S_MARK;
                end
            end
            tcv_pkg::S_MARK: begin
                if (adv) begin
                    o_push  = 1'b1;
                    n_state = tcv_pkg::S_IDLE;
                end
            end
            default: ;
        endcase

        if (acc) begin
            n_state   = n_started ? tcv_pkg::S_STEP : tcv_pkg::S_PRE;
            n_started = 1'b1;
            n_final   = i_eoi;
            n_ws      = 3'd0;
            n_wb[0]   = n_held[0];
            n_wb[1]   = n_held[1];
            n_wb[2]   = n_held[2];
            if (i_eoi) begin
                n_wn   = {1'b0, n_hcnt};
                n_hcnt = 2'd0;
            end else if (n_in_code && n_skip && (i_byte == " " || i_byte == "\t")) begin
                n_prev = i_byte;
                n_wn   = 3'd0;
            end else begin
                n_skip         = 1'b0;
                n_wb[n_hcnt]   = i_byte;
                n_wn           = {1'b0, n_hcnt} + 3'd1;
                n_hcnt         = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tcv_pkg::S_IDLE;
            r_started <= 1'b0;
            r_in_code <= 1'b0;
            r_skip    <= 1'b0;
            r_seg     <= 1'b0;
            r_inq     <= 1'b0;
            r_prev    <= 8'd0;
            r_hcnt    <= 2'd0;
            r_wn      <= 3'd0;
            r_ws      <= 3'd0;
            r_final   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_in_code <= n_in_code;
            r_skip    <= n_skip;
            r_seg     <= n_seg;
            r_inq     <= n_inq;
            r_prev    <= n_prev;
            r_hcnt    <= n_hcnt;
            r_wn      <= n_wn;
            r_ws      <= n_ws;
            r_final   <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_wb   <= n_wb;
    end

`ifndef ASSERT_OFF
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_state != tcv_pkg::S_IDLE) else $error("accepted item left front idle");
    a_code_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_code |-> !r_seg) else $error("print open inside code block");
    a_skip_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> r_in_code) else $error("blank skipping outside code block");
`endif

endmodule

// ----- rtl/core/tcv_fifo.sv -----
// tcv_fifo: short token queue between the front and back parts
module tcv_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tcv_pkg::t_tok   i_tok,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tcv_pkg::t_tok   o_head
);

    tcv_pkg::t_tok r_mem [tcv_pkg::QDEPTH];
    logic [$clog2(tcv_pkg::QDEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(tcv_pkg::QDEPTH):0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == ($clog2(tcv_pkg::QDEPTH)+1)'(tcv_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_tok;
    end

endmodule

// ----- rtl/core/tcv_back.sv -----
// tcv_back: expands tokens into script bytes and marks the last byte of each item
module tcv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tcv_pkg::t_tok   i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    logic [4:0] r_idx, n_idx, len;
    logic [7:0] bt, r_pb, n_pb, r_ob, n_ob;
    logic       r_pv, n_pv, r_pl, n_pl, r_ov, n_ov, r_ol, n_ol;
    logic       e_byte, e_mark, out_free, pend_go, take;

    assign len    = tcv_pkg::tok_len(i_head);
    assign bt     = tcv_pkg::tok_byte(i_head, r_idx);
    assign e_byte = !i_empty && (i_head.kind != tcv_pkg::K_MARK);
    assign e_mark = !i_empty && (i_head.kind == tcv_pkg::K_MARK);
    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_ol;

    always_comb begin
        out_free = !r_ov || !i_stall;
        pend_go  = r_pv && (r_pl || e_byte) && out_free;
        take     = e_byte ? (!r_pv || pend_go) :
                   e_mark ? (!r_pv || !r_pl || pend_go) : 1'b0;
        o_pop    = take && (r_idx == len - 5'd1);
        n_idx    = r_idx;
        if (take) n_idx = o_pop ? 5'd0 : r_idx + 5'd1;

        n_pv = r_pv;
        n_pl = r_pl;
        n_pb = r_pb;
        if (pend_go) n_pv = 1'b0;
        if (take && e_byte) begin
            n_pv = 1'b1;
            n_pb = bt;
            n_pl = 1'b0;
        end else if (take && e_mark && r_pv && !r_pl) begin
            n_pl = 1'b1;
        end

        n_ov = r_ov;
        n_ob = r_ob;
        n_ol = r_ol;
        if (out_free) begin
            n_ov = pend_go;
            n_ob = r_pb;
            n_ol = r_pl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 5'd0;
            r_pv  <= 1'b0;
            r_pl  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_pv  <= n_pv;
            r_pl  <= n_pl;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pb <= n_pb;
        r_ob <= n_ob;
        r_ol <= n_ol;
    end

endmodule

// ----- rtl/core/template_to_script_converter.sv -----
// template_to_script_converter: template document bytes in, script source bytes out
//
//  channel | direction | handshake                   | payload
//  in      | in        | i_in_valid / o_in_stall     | i_in_byte, i_end_of_input
//  out     | out       | o_out_valid / i_out_stall   | o_out_byte, o_run_last
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// the front stalls its input while it works on an item and takes the next item
// once its mark is queued; held delimiter bytes are replayed, and a preamble or
// an end of document adds a state; the back emits one byte per cycle unless stalled
// a 4-entry token queue lets front and back stall on their own
// synchronous active-low reset returns to text mode with the preamble pending
module template_to_script_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    tcv_pkg::t_tok push_tok, head_tok;
    logic          push, q_full, q_empty, pop;

    tcv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_byte      (i_in_byte),
        .i_eoi       (i_end_of_input),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_tok       (push_tok),
        .i_q_full    (q_full)
    );

    tcv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_tok)
    );

    tcv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_tok),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_byte  (o_out_byte),
        .o_last  (o_run_last)
    );

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench of the template to script converter
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte = 8'd0;
    logic        i_end_of_input = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [31:0] i_cfg_data = 32'd0;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
    } t_script_byte;

    t_script_byte script_q[$];
    int           errors = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_cycles = 0;
    int           items_sent = 0;

    // converter state kept by the testbench
    logic [31:0] m_bdel = 32'd16188;
    logic [31:0] m_edel = 32'd15905;
    logic [2:0]  m_blen = 3'd2;
    logic [2:0]  m_elen = 3'd2;
    bit          m_started, m_in_code, m_skip, m_seg, m_inq;
    logic [7:0]  m_prev = 8'd0;
    logic [7:0]  m_held[8];
    int          m_hcnt;
    logic [7:0]  ob[64];
    int          oc;

    template_to_script_converter DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void put(logic [7:0] c);
        if (oc < 64) begin
            ob[oc] = c;
            oc++;
        end
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    function automatic int dlen(logic [2:0] r);
        int v;
        v = r;
        if (v < 1) v = 1;
        if (v > tcv_pkg::LEN_CAP) v = tcv_pkg::LEN_CAP;
        return v;
    endfunction

    function automatic logic [7:0] dbyte(logic [31:0] d, int i);
        return (i < 4) ? d[8*i +: 8] : 8'd0;
    endfunction

    function automatic void text_ch(logic [7:0] c);
        if (!m_seg) begin
            put_str("print \"");
            m_seg = 1;
        end
        case (c)
            "\"", "@", "$", "\\": begin
                put("\\");
                put(c);
            end
            "\t": begin
                put("\\");
                put("t");
            end
            "\n": begin
                put_str("\\n\";\n");
                put_str("print \"");
            end
            default: put(c);
        endcase
    endfunction

    function automatic void close_txt();
        if (m_seg) begin
            put_str("\";");
            m_seg = 0;
        end
    endfunction

    function automatic void code_ch(logic [7:0] c);
        if (c == "\"" && m_prev != "\\") m_inq = !m_inq;
        put(c);
        m_prev = c;
    endfunction

    function automatic bit is_pre(logic [7:0] b[8], int s, int n, logic [31:0] d);
        for (int i = 0; i < n; i++)
            if (b[s+i] != dbyte(d, i)) return 0;
        return 1;
    endfunction

    function automatic void settle(logic [7:0] b[8], int n, bit fin);
        int s;
        int rem;
        int len;
        bit q;
        s = 0;
        m_hcnt = 0;
        while (s < n) begin
            rem = n - s;
            if (!m_in_code) begin
                len = dlen(m_blen);
                if (!fin && rem <= len && is_pre(b, s, rem, m_bdel)) begin
                    if (rem == len) begin
                        close_txt();
                        m_in_code = 1;
                        m_skip = 1;
                        m_inq = 0;
                        m_prev = dbyte(m_bdel, len - 1);
                    end else begin
                        for (int i = 0; i < rem; i++) m_held[i] = b[s+i];
                        m_hcnt = rem;
                    end
                    return;
                end
                text_ch(b[s]);
            end else begin
                len = dlen(m_elen);
                q = (b[s] == "\"" && m_prev != "\\");
                if (!fin && !m_inq && !q && rem <= len && is_pre(b, s, rem, m_edel)) begin
                    if (rem == len) m_in_code = 0;
                    else begin
                        for (int i = 0; i < rem; i++) m_held[i] = b[s+i];
                        m_hcnt = rem;
                    end
                    return;
                end
                code_ch(b[s]);
            end
            s++;
        end
    endfunction

    function automatic void clear_doc();
        m_started = 0;
        m_in_code = 0;
        m_skip = 0;
        m_seg = 0;
        m_inq = 0;
        m_prev = 8'd0;
        m_hcnt = 0;
    endfunction

    function automatic void convert_item(logic [7:0] c, logic eoi);
        logic [7:0] b[8];
        int n;
        t_script_byte e;
        oc = 0;
        n = m_hcnt & 3;
        if (!m_started) begin
            put_str("$| = 1;");
            m_started = 1;
        end
        for (int i = 0; i < 8; i++) b[i] = (i < n) ? m_held[i] : 8'd0;
        if (eoi) begin
            settle(b, n, 1);
            if (!m_in_code) close_txt();
            clear_doc();
        end else if (m_in_code && m_skip && (c == " " || c == "\t")) begin
            m_prev = c;
        end else begin
            m_skip = 0;
            b[n] = c;
            settle(b, n + 1, 0);
        end
        for (int i = 0; i < oc; i++) begin
            e.out_byte = ob[i];
            e.run_last = (i == oc - 1);
            script_q.push_back(e);
        end
    endfunction

    // result side: checks every transfer and drives the stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (script_q.size() == 0) begin
                $display("%0t: out_byte expected none actual %h", $realtime, o_out_byte);
                errors++;
            end else begin
                if (o_out_byte !== script_q[0].out_byte) begin
                    $display("%0t: out_byte expected %h actual %h", $realtime,
                             script_q[0].out_byte, o_out_byte);
                    errors++;
                end
                if (o_run_last !== script_q[0].run_last) begin
                    $display("%0t: run_last expected %b actual %b", $realtime,
                             script_q[0].run_last, o_run_last);
                    errors++;
                end
                void'(script_q.pop_front());
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_item(logic [7:0] c, logic eoi);
        i_in_valid <= 1'b1;
        i_in_byte <= c;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        convert_item(c, eoi);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_byte <= 8'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (script_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            tcv_pkg::CFG_BEGIN_DELIM: m_bdel = data;
            tcv_pkg::CFG_BEGIN_LEN:   m_blen = data[2:0];
            tcv_pkg::CFG_END_DELIM:   m_edel = data;
            tcv_pkg::CFG_END_LEN:     m_elen = data[2:0];
            default: ;
        endcase
    endtask

    task automatic set_delims(logic [31:0] bd, logic [2:0] bl, logic [31:0] ed,
                              logic [2:0] el);
        write_reg(tcv_pkg::CFG_BEGIN_DELIM, bd);
        write_reg(tcv_pkg::CFG_BEGIN_LEN, {29'd0, bl});
        write_reg(tcv_pkg::CFG_END_DELIM, ed);
        write_reg(tcv_pkg::CFG_END_LEN, {29'd0, el});
    endtask

    task automatic send_delim(logic [31:0] d, logic [2:0] l, int cnt);
        for (int i = 0; i < cnt && i < dlen(l); i++) send_item(dbyte(d, i), 1'b0);
    endtask

    task automatic random_doc(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 12) send_delim(m_bdel, m_blen, 4);
            else if (r < 24) send_delim(m_edel, m_elen, 4);
            else if (r < 30) send_delim($urandom_range(1) ? m_bdel : m_edel, 3'd4,
                                        $urandom_range(1, 3));
            else if (r < 50) begin
                case ($urandom_range(6))
                    0: send_item("\"", 1'b0);
                    1: send_item("\\", 1'b0);
                    2: send_item(" ", 1'b0);
                    3: send_item("\t", 1'b0);
                    4: send_item("\n", 1'b0);
                    5: send_item("@", 1'b0);
                    default: send_item("$", 1'b0);
                endcase
            end else send_item(8'($urandom), 1'b0);
        end
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b1);
        send_str("a\"@$\\\t\n");
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_str("<? \t x\"!>\\\"!>\"!>");
        send_str("!<<");
        send_item(8'h00, 1'b1);
        send_str("<?q\"");
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_config_extremes();
        set_delims(32'h0000_0000, 3'd0, 32'hffff_ffff, 3'd7);
        random_doc(20);
        set_delims(32'h2324_2526, 3'd4, 32'h2526_2324, 3'd1);
        random_doc(20);
        set_delims(32'hffff_ff7b, 3'd1, 32'h0000_7d7d, 3'd4);
        random_doc(20);
        set_delims(32'h0000_3f3c, 3'd5, 32'h0000_3e21, 3'd3);
        random_doc(15);
        set_delims(32'd16188, 3'd2, 32'd15905, 3'd2);
    endtask

    task automatic test_random_phase(int sidle, int rstall, int items);
        int start;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        start = items_sent;
        while (items_sent - start < items) random_doc($urandom_range(4, 20));
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        random_doc(30);
        drain();
        random_doc(10);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random_phase(0, 0, 50);
        test_random_phase(68, 0, 35);
        test_random_phase(0, 68, 35);
        test_random_phase(34, 34, 35);
        test_backpressure();
        drain();
        if (errors == 0 && script_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            if (script_q.size() != 0)
                $display("%0t: %0d expected bytes never arrived", $realtime,
                         script_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/tcv_pkg.sv
rtl/core/tcv_front.sv
rtl/core/tcv_fifo.sv
rtl/core/tcv_back.sv
rtl/core/template_to_script_converter.sv
tb/tb.sv
